// File: rtl/kds_pkg.sv
package kds_pkg;

  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 4;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

  // Request codes.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_TAKE = 2'd2;

  // Register indexes (byte address is 8 times the index).
  localparam int ADDR_W = 6;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_COL_PINS   = 3'd1;
  localparam logic [2:0] REG_KEYMAP_LO  = 3'd2;
  localparam logic [2:0] REG_KEYMAP_HI  = 3'd3;
  localparam logic [2:0] REG_NO_KEY     = 3'd4;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [63:0] column_pins;
    logic [63:0] keymap_rows_low;
    logic [63:0] keymap_rows_high;
    logic [7:0]  no_key_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] edge_pin;
    logic [3:0]  rows_pulling_low;
  } item_t;

  typedef struct packed {
    logic [7:0] taken_key;
    logic       column_matched;
    logic [1:0] column_found;
    logic       scan_done;
    logic       key_pending;
  } result_t;

  // Key code of one keypad position.
  function automatic logic [7:0] keymap_byte(input cfg_t cfg, input logic [1:0] row,
                                             input logic [1:0] col);
    logic [63:0] word;
    logic [2:0]  idx;
    word = row[1] ? cfg.keymap_rows_high : cfg.keymap_rows_low;
    idx  = {row[0], col};
    return word[idx*8 +: 8];
  endfunction

endpackage

// File: rtl/kds_regs.sv
module kds_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kds_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output kds_pkg::cfg_t              cfg
);
  import kds_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:3];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= DEBOUNCE_RESET;
      cfg.column_pins      <= '0;
      cfg.keymap_rows_low  <= '0;
      cfg.keymap_rows_high <= '0;
      cfg.no_key_code      <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DEBOUNCE:  cfg.debounce_ms      <= pwdata[15:0];
        REG_COL_PINS:  cfg.column_pins      <= pwdata;
        REG_KEYMAP_LO: cfg.keymap_rows_low  <= pwdata;
        REG_KEYMAP_HI: cfg.keymap_rows_high <= pwdata;
        REG_NO_KEY:    cfg.no_key_code      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DEBOUNCE:  prdata = {48'd0, cfg.debounce_ms};
      REG_COL_PINS:  prdata = cfg.column_pins;
      REG_KEYMAP_LO: prdata = cfg.keymap_rows_low;
      REG_KEYMAP_HI: prdata = cfg.keymap_rows_high;
      REG_NO_KEY:    prdata = {56'd0, cfg.no_key_code};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/kds_engine.sv
module kds_engine (
  input  logic              clk,
  input  logic              rst,
  input  kds_pkg::cfg_t     cfg,
  input  kds_pkg::item_t    item,
  input  logic              fire,
  output kds_pkg::result_t  result
);
  import kds_pkg::*;

  logic [31:0] tick_count;
  logic [31:0] tick_count_next;
  logic [31:0] last_edge_time;
  logic [31:0] last_edge_time_next;
  logic [7:0]  held_key;
  logic [7:0]  held_key_next;

  logic        matched;
  logic [1:0]  col;
  logic        row_hit;
  logic [1:0]  row;
  logic        debounced;
  logic [31:0] elapsed;
  logic [7:0]  key;

  // Lowest configured column whose pin code matches.
  always_comb begin
    matched = 1'b0;
    col     = '0;
    for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
      if (cfg.column_pins[c*16 +: 16] == item.edge_pin) begin
        matched = 1'b1;
        col     = 2'(c);
      end
    end
  end

  // Lowest pulling row.
  always_comb begin
    row_hit = 1'b0;
    row     = '0;
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (item.rows_pulling_low[r]) begin
        row_hit = 1'b1;
        row     = 2'(r);
      end
    end
  end

  assign elapsed   = tick_count - last_edge_time;
  assign debounced = elapsed > {16'd0, cfg.debounce_ms};
  assign key       = keymap_byte(cfg, row, col);

  always_comb begin
    tick_count_next     = tick_count;
    last_edge_time_next = last_edge_time;
    held_key_next       = held_key;
    result.taken_key      = cfg.no_key_code;
    result.column_matched = 1'b0;
    result.column_found   = '0;
    result.scan_done      = 1'b0;
    case (item.req_type)
      REQ_TICK: tick_count_next = tick_count + 32'd1;
      REQ_EDGE: begin
        if (matched) begin
          result.column_matched = 1'b1;
          result.column_found   = col;
          last_edge_time_next   = tick_count;
          if (debounced) begin
            result.scan_done = 1'b1;
            if (row_hit && key != cfg.no_key_code) begin
              held_key_next = key;
            end
          end
        end
      end
      REQ_TAKE: begin
        result.taken_key = held_key;
        held_key_next    = cfg.no_key_code;
      end
      default: ;
    endcase
    result.key_pending = held_key_next != cfg.no_key_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      last_edge_time <= '0;
      held_key       <= '0;
    end else if (fire) begin
      tick_count     <= tick_count_next;
      last_edge_time <= last_edge_time_next;
      held_key       <= held_key_next;
    end
  end

endmodule

// File: rtl/matrix_keypad_debounced_scanner.sv
// Stages: an accepted request passes the input register, then the result
// register, whose contents drive the output port (two register stages).
// Throughput: one request per cycle unless stalled; each yields exactly one result.
// Reset (rst, synchronous, active high) empties both stages, loads the register
// defaults (debounce 50 ms, all other registers zero) and clears the tick count,
// the last edge time and the buffered key.
module matrix_keypad_debounced_scanner (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 req_type,
  input  logic [15:0]                edge_pin,
  input  logic [3:0]                 rows_pulling_low,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 taken_key,
  output logic                       column_matched,
  output logic [1:0]                 column_found,
  output logic                       scan_done,
  output logic                       key_pending,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kds_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import kds_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_advance;
  logic    in_accept;
  result_t result;
  result_t out_result;

  // Register file on the APB-style port.
  kds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The input stage moves on whenever the result register is empty or is being
  // emptied in this cycle. The keypad state is updated at that same edge, so the
  // next request in the input stage always sees the state left by this one.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.req_type         <= req_type;
      s1_item.edge_pin         <= edge_pin;
      s1_item.rows_pulling_low <= rows_pulling_low;
    end
  end

  // Column match, row priority, keymap lookup, the debounce compare, tick count and held key.
  kds_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (s1_item),
    .fire   (s1_advance),
    .result (result)
  );

  // Result register. It holds its contents while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_result <= result;
    end
  end

  assign taken_key      = out_result.taken_key;
  assign column_matched = out_result.column_matched;
  assign column_found   = out_result.column_found;
  assign scan_done      = out_result.scan_done;
  assign key_pending    = out_result.key_pending;

endmodule

// File: rtl/kds_checker.sv
module kds_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] taken_key,
  input logic       column_matched,
  input logic [1:0] column_found,
  input logic       scan_done,
  input logic       key_pending,
  input logic       pready
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(taken_key) && $stable(scan_done)
      && $stable(key_pending) && $stable(column_matched) && $stable(column_found))
    else $error("result changed while stalled");

  // A scan only happens on a matched column.
  a_scan_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_done |-> column_matched)
    else $error("scan without column match");

  // An unmatched item reports column zero.
  a_col_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !column_matched |-> column_found == 2'd0)
    else $error("column index without match");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind matrix_keypad_debounced_scanner kds_checker u_kds_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .taken_key      (taken_key),
  .column_matched (column_matched),
  .column_found   (column_found),
  .scan_done      (scan_done),
  .key_pending    (key_pending),
  .pready         (pready)
);
